// ===== hdl/lcs_pkg.sv =====
// shared constants, types and helpers of the locality cluster segmenter
package lcs_pkg;

    // sizing
    localparam int MAX_WINDOW = 16;
    localparam int ADDR_BITS  = 48;
    localparam int WLEN_W     = 5;
    localparam int LEN_W      = 32;
    localparam int SUM_W      = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int K_W        = $clog2(MAX_WINDOW + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = CFG_IDX_W'(1);

    // reset values of the registers
    localparam logic [ADDR_BITS-1:0] MAX_DISTANCE_RST = ADDR_BITS'(4096);
    localparam logic [WLEN_W-1:0]    WINDOW_LEN_RST   = WLEN_W'(8);

    typedef logic [ADDR_BITS-1:0] t_addr;

    // one input request
    typedef struct packed {
        t_addr address;
        logic  trace_first;
        logic  trace_last;
    } t_in_item;

    // one result
    typedef struct packed {
        logic             boundary;
        logic [LEN_W-1:0] closed_length;
        logic [LEN_W-1:0] current_length;
        t_addr            jump_distance;
        logic [LEN_W-1:0] cluster_count;
        logic [SUM_W-1:0] jump_sum;
        logic             trace_done;
    } t_out_item;

    // window update commands to the cell chain
    typedef struct packed {
        logic shift;
        logic restart;
        logic clear;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // absolute difference of two addresses
    function automatic t_addr abs_diff(t_addr a, t_addr b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // saturating increment of a length or count
    function automatic logic [LEN_W-1:0] sat_inc(logic [LEN_W-1:0] v);
        return (v == '1) ? v : v + LEN_W'(1);
    endfunction

endpackage

// ===== hdl/lcs_if.sv =====
// request, result and configuration channel interfaces
interface lcs_in_if import lcs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lcs_out_if import lcs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lcs_cfg_if import lcs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/lcs_cell.sv =====
// one window cell: holds an address, compares it and hands it to the next cell
module lcs_cell import lcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head,
    input  t_addr     i_addr,
    input  t_addr     i_max_dist,
    input  logic      i_check_en,
    input  t_addr     i_left_data,
    input  logic      i_left_valid,
    input  t_cell_ctl i_ctl,
    output t_addr     o_data,
    output logic      o_valid,
    output logic      o_fail
);

    logic  r_valid;
    logic  n_valid;
    t_addr r_data;
    t_addr n_data;
    logic  r_fail;

    // next entry: clear beats restart beats shift
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.restart) begin
            n_valid = i_head;
            n_data  = i_addr;
        end else if (i_ctl.shift) begin
            n_valid = i_left_valid;
            n_data  = i_left_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload and registered distance check
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_fail <= r_valid && i_check_en && (abs_diff(i_addr, r_data) > i_max_dist);
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_fail  = r_fail;

endmodule

// ===== hdl/lcs_ctrl.sv =====
// sequencer: request capture, cluster counters and result register
module lcs_ctrl import lcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lcs_in_if.sink                i_in,
    lcs_out_if.source             o_out,
    input  logic [MAX_WINDOW-1:0] i_fail,
    output t_addr                 o_addr,
    output t_cell_ctl             o_ctl
);

    t_state           r_state;
    t_state           n_state;
    t_in_item         r_item;
    t_addr            r_prev;
    t_addr            r_jump;
    logic [LEN_W-1:0] r_open;
    logic [LEN_W-1:0] r_count;
    logic [SUM_W-1:0] r_total;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             w_accept;
    logic             w_upd;
    logic             w_out_free;
    logic [LEN_W-1:0] n_open;
    logic [LEN_W-1:0] n_count;
    logic [SUM_W-1:0] n_total;
    t_out_item        n_out;
    t_cell_ctl        n_ctl;
    logic [LEN_W-1:0] w_eff_open;
    logic [LEN_W-1:0] w_eff_count;
    logic [SUM_W-1:0] w_eff_total;
    logic [SUM_W:0]   w_sum;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_upd      = (r_state == ST_UPD) && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_in.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_CMP:  i_in.ready = 1'b0;
            ST_UPD:  i_in.ready = 1'b0;
            default: i_in.ready = 1'b0;
        endcase
    end

    // cluster decision, counters and result
    always_comb begin
        w_eff_open  = r_item.trace_first ? '0 : r_open;
        w_eff_count = r_item.trace_first ? '0 : r_count;
        w_eff_total = r_item.trace_first ? '0 : r_total;
        w_sum       = {1'b0, w_eff_total} + (SUM_W + 1)'(r_jump);
        n_ctl       = '0;
        n_open      = w_eff_open;
        n_count     = w_eff_count;
        n_total     = w_eff_total;
        n_out       = '0;
        if (w_eff_open == '0) begin
            // first reference of a trace
            n_ctl.restart = 1'b1;
            n_open        = LEN_W'(1);
            n_count       = sat_inc(w_eff_count);
        end else if (i_fail == '0) begin
            // joins the open cluster
            n_ctl.shift = 1'b1;
            n_open      = sat_inc(w_eff_open);
        end else begin
            // closes the open cluster
            n_ctl.restart       = 1'b1;
            n_open              = LEN_W'(1);
            n_count             = sat_inc(w_eff_count);
            n_total             = w_sum[SUM_W] ? '1 : w_sum[SUM_W-1:0];
            n_out.boundary      = 1'b1;
            n_out.closed_length = w_eff_open;
            n_out.jump_distance = r_jump;
        end
        n_out.current_length = n_open;
        n_out.cluster_count  = n_count;
        n_out.jump_sum       = n_total;
        n_out.trace_done     = r_item.trace_last;
        n_ctl.clear          = r_item.trace_last;
        if (!w_upd) begin
            n_ctl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev      <= '0;
            r_open      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd) begin
                r_out_valid <= 1'b1;
                if (r_item.trace_last) begin
                    r_prev  <= '0;
                    r_open  <= '0;
                    r_count <= '0;
                    r_total <= '0;
                end else begin
                    r_prev  <= r_item.address;
                    r_open  <= n_open;
                    r_count <= n_count;
                    r_total <= n_total;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in.data;
        end
        if (r_state == ST_CMP) begin
            r_jump <= abs_diff(r_item.address, r_prev);
        end
        if (w_upd) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign o_addr      = r_item.address;
    assign o_ctl       = n_ctl;

    // checks
    default disable iff (!i_rst_n);

    a_seq: assert property (@(posedge i_clk) w_accept |=> r_state == ST_CMP ##1 r_state == ST_UPD)
        else $error("request did not walk through compare and update");

    a_boundary_len: assert property (@(posedge i_clk)
        (r_out_valid && r_out.boundary) |->
        (r_out.current_length == LEN_W'(1) && r_out.closed_length != '0))
        else $error("boundary result with bad lengths");

    a_ctl_excl: assert property (@(posedge i_clk) $onehot0({o_ctl.shift, o_ctl.restart}))
        else $error("window shift and restart together");

    a_open_count: assert property (@(posedge i_clk) (r_open == '0) == (r_count == '0))
        else $error("open length and cluster count disagree");

    a_ctl_upd: assert property (@(posedge i_clk)
        (o_ctl.shift || o_ctl.restart || o_ctl.clear) |-> w_upd)
        else $error("window changed outside update");

endmodule

// ===== hdl/locality_cluster_segmenter.sv =====
// top level: configuration registers, window cell chain and sequencer
//
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      address, trace_first, trace_last
//  o_out     out  valid / ready      boundary .. trace_done result
//  i_cfg     in   valid / ready      index, wdata (0 max_distance, 1 window_len)
//
//  each request goes through capture, window compare and update; the
//  window compare runs in parallel in the cells, the update waits on the
//  result register. a result left waiting holds the update step; the next
//  request is taken as soon as the update is done. reset is synchronous,
//  active low, and needs no clearing pass. configuration is always ready.
module locality_cluster_segmenter import lcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lcs_in_if.sink    i_in,
    lcs_out_if.source o_out,
    lcs_cfg_if.sink   i_cfg
);

    t_addr             r_max_dist;
    logic [WLEN_W-1:0] r_wlen;
    logic [K_W-1:0]    w_k;
    logic [MAX_WINDOW-1:0] w_en;
    logic [MAX_WINDOW-1:0] w_fail;
    logic [MAX_WINDOW-1:0] w_valid;
    t_addr             w_data [MAX_WINDOW];
    t_addr             w_addr;
    t_cell_ctl         w_ctl;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DISTANCE_RST;
            r_wlen     <= WINDOW_LEN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MAX_DISTANCE: r_max_dist <= i_cfg.wdata[ADDR_BITS-1:0];
                REG_WINDOW_LEN:   r_wlen     <= i_cfg.wdata[WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective window length and per-cell check enables
    always_comb begin
        if (r_wlen == '0) begin
            w_k = K_W'(1);
        end else if (32'(r_wlen) > MAX_WINDOW) begin
            w_k = K_W'(MAX_WINDOW);
        end else begin
            w_k = K_W'(r_wlen);
        end
    end

    // sequencer
    lcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_fail  (w_fail),
        .o_addr  (w_addr),
        .o_ctl   (w_ctl)
    );

    // cell chain, newest entry in cell zero
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        assign w_en[g] = (K_W'(g) < w_k);

        lcs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_head       ((g == 0) ? 1'b1 : 1'b0),
            .i_addr       (w_addr),
            .i_max_dist   (r_max_dist),
            .i_check_en   (w_en[g]),
            .i_left_data  ((g == 0) ? w_addr : w_data[(g == 0) ? 0 : g - 1]),
            .i_left_valid ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g - 1]),
            .i_ctl        (w_ctl),
            .o_data       (w_data[g]),
            .o_valid      (w_valid[g]),
            .o_fail       (w_fail[g])
        );
    end

endmodule

// ===== tb/sv/tb_locality_cluster_segmenter.sv =====
// testbench of the locality cluster segmenter: random traces checked against a predictor
`timescale 1ns / 1ps

module tb_locality_cluster_segmenter;
    import lcs_pkg::*;

    localparam int CLK_HALF_NS       = 10;
    localparam int RESET_CYCLES      = 12;
    localparam int SETTLE_CYCLES     = 8;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int TIMEOUT_NS        = 10_000_000;
    localparam int PHASE_REFS        = 230;

    // an index that maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(9);

    logic i_clk;
    logic i_rst_n;

    lcs_in_if  in_ch ();
    lcs_out_if out_ch ();
    lcs_cfg_if cfg_ch ();

    locality_cluster_segmenter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // requests waiting to be offered and results still owed by the block
    t_in_item  refs_to_send[$];
    t_out_item reports_due[$];

    int  fail_count     = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  long_stall_arm = 1'b0;
    logic rx_hold;

    // predictor copy of the registers
    t_addr             cfg_max_dist = MAX_DISTANCE_RST;
    logic [WLEN_W-1:0] cfg_wlen     = WINDOW_LEN_RST;

    // predictor copy of the segmenter state, newest window entry at 0
    t_addr            win_addr [MAX_WINDOW];
    int               win_count;
    t_addr            last_addr;
    logic [LEN_W-1:0] run_len;
    logic [LEN_W-1:0] cluster_total;
    logic [SUM_W-1:0] jump_acc;

    function automatic t_addr gap(t_addr a, t_addr b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [LEN_W-1:0] bump32(logic [LEN_W-1:0] v);
        return (v == {LEN_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic void forget_trace();
        foreach (win_addr[i]) win_addr[i] = '0;
        win_count     = 0;
        last_addr     = '0;
        run_len       = '0;
        cluster_total = '0;
        jump_acc      = '0;
    endfunction

    function automatic void open_window(t_addr a);
        foreach (win_addr[i]) win_addr[i] = '0;
        win_addr[0] = a;
        win_count   = 1;
    endfunction

    // expected result of one reference; advances the predictor state
    function automatic t_out_item segment_ref(t_in_item r);
        t_out_item        res;
        int               k;
        int               n;
        bit               fits;
        t_addr            d;
        logic [SUM_W-1:0] room;
        res = '0;
        if (r.trace_first) forget_trace();
        if (run_len == '0) begin
            open_window(r.address);
            run_len       = LEN_W'(1);
            cluster_total = bump32(cluster_total);
        end else begin
            // window length 0 behaves as 1, above the store depth as full depth
            k = (cfg_wlen == '0) ? 1 :
                (int'(cfg_wlen) > MAX_WINDOW ? MAX_WINDOW : int'(cfg_wlen));
            n = (win_count > k) ? k : win_count;
            fits = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (gap(r.address, win_addr[i]) > cfg_max_dist) fits = 1'b0;
            end
            if (fits) begin
                for (int i = MAX_WINDOW - 1; i > 0; i--) win_addr[i] = win_addr[i-1];
                win_addr[0] = r.address;
                if (win_count < MAX_WINDOW) win_count++;
                run_len = bump32(run_len);
            end else begin
                d = gap(r.address, last_addr);
                res.boundary      = 1'b1;
                res.closed_length = run_len;
                res.jump_distance = d;
                room = {SUM_W{1'b1}} - SUM_W'(d);
                jump_acc = (jump_acc > room) ? {SUM_W{1'b1}} : jump_acc + SUM_W'(d);
                cluster_total = bump32(cluster_total);
                run_len = LEN_W'(1);
                open_window(r.address);
            end
        end
        last_addr          = r.address;
        res.current_length = run_len;
        res.cluster_count  = cluster_total;
        res.jump_sum       = jump_acc;
        res.trace_done     = r.trace_last;
        if (r.trace_last) forget_trace();
        return res;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #TIMEOUT_NS;
        $display("FAIL locality_cluster_segmenter");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                reports_due = {reports_due, segment_ref(in_ch.data)};
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (refs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.data  <= refs_to_send.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin : p_monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (reports_due.size() == 0) begin
                    $error("result 0x%0h arrived with no request waiting", out_ch.data);
                    fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    compare_field("boundary", 64'(want.boundary),
                                  64'(out_ch.data.boundary));
                    compare_field("closed_length", 64'(want.closed_length),
                                  64'(out_ch.data.closed_length));
                    compare_field("current_length", 64'(want.current_length),
                                  64'(out_ch.data.current_length));
                    compare_field("jump_distance", 64'(want.jump_distance),
                                  64'(out_ch.data.jump_distance));
                    compare_field("cluster_count", 64'(want.cluster_count),
                                  64'(out_ch.data.cluster_count));
                    compare_field("jump_sum", want.jump_sum, out_ch.data.jump_sum);
                    compare_field("trace_done", 64'(want.trace_done),
                                  64'(out_ch.data.trace_done));
                end
            end
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here once armed
    initial begin
        rx_hold = 1'b0;
        wait (long_stall_arm);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    function automatic void add_ref(t_addr a, bit first, bit last);
        t_in_item r;
        r.address     = a;
        r.trace_first = first;
        r.trace_last  = last;
        refs_to_send  = {refs_to_send, r};
    endfunction

    // next address of a random walk around the current one
    function automatic t_addr next_addr(t_addr a);
        logic [63:0] delta;
        bit          down;
        down = 1'($urandom_range(1));
        case ($urandom_range(9))
            0: return t_addr'({$urandom, $urandom});
            1: return a;
            2: delta = 64'(cfg_max_dist);
            3: delta = 64'(cfg_max_dist) + 64'd1;
            4, 5, 6, 7: delta = {$urandom, $urandom} % (64'(cfg_max_dist) + 64'd1);
            default: delta = 64'($urandom_range(15));
        endcase
        return down ? a - t_addr'(delta) : a + t_addr'(delta);
    endfunction

    // well-formed traces with random content, some flags scrambled
    task automatic queue_random_refs(int count);
        int    made;
        int    span;
        t_addr a;
        bit    f;
        bit    l;
        made = 0;
        a = t_addr'({$urandom, $urandom});
        while (made < count) begin
            span = int'($urandom_range(40, 1));
            for (int j = 0; j < span && made < count; j++) begin
                a = next_addr(a);
                f = (j == 0);
                l = (j == span - 1);
                if ($urandom_range(99) < 8) f = 1'($urandom_range(1));
                if ($urandom_range(99) < 8) l = 1'($urandom_range(1));
                add_ref(a, f, l);
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (refs_to_send.size() != 0 || in_ch.valid || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_MAX_DISTANCE) cfg_max_dist = value[ADDR_BITS-1:0];
        else if (idx == REG_WINDOW_LEN) cfg_wlen = value[WLEN_W-1:0];
        cfg_ch.valid <= 1'b0;
    endtask

    // drain, then reprogram both registers and the idling mix
    task automatic set_phase(logic [63:0] max_dist, logic [63:0] wlen, int send_pct,
                             int recv_pct);
        wait_idle();
        write_reg(REG_MAX_DISTANCE, max_dist);
        write_reg(REG_WINDOW_LEN, wlen);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // sequence of phases
    initial begin
        forget_trace();
        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at the reset settings
        add_ref(48'h0, 1'b1, 1'b0);
        add_ref(48'd4096, 1'b0, 1'b0);            // exactly at the distance limit
        add_ref(48'd4097, 1'b0, 1'b0);            // one past it against the oldest entry
        add_ref(48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);  // jump up to the largest address
        add_ref(48'h0, 1'b0, 1'b0);               // largest jump down
        add_ref(48'h0, 1'b0, 1'b1);               // trace end
        add_ref(48'd5, 1'b0, 1'b0);               // no trace_first after a trace end
        add_ref(48'd2000, 1'b0, 1'b0);
        add_ref(48'd4000, 1'b0, 1'b0);
        add_ref(48'd6000, 1'b0, 1'b0);            // close to newest, too far from oldest
        add_ref(48'd7, 1'b1, 1'b1);               // single-reference trace
        add_ref(48'd100, 1'b1, 1'b0);
        add_ref(48'd100, 1'b1, 1'b0);             // restart in the middle of a trace
        add_ref(48'hAAAA_AAAA_AAAA, 1'b0, 1'b0);
        add_ref(48'h5555_5555_5555, 1'b0, 1'b0);
        add_ref(48'h5555_5555_5000, 1'b0, 1'b1);
        wait_idle();
        write_reg(REG_UNMAPPED, {CFG_DATA_W{1'b1}});

        set_phase(64'd4096, 64'd8, 0, 0);
        queue_random_refs(PHASE_REFS);

        // zero distance, every different address splits
        set_phase(64'd0, 64'd1, 47, 0);
        queue_random_refs(PHASE_REFS);

        // high bits dropped, window length above the store depth
        set_phase({CFG_DATA_W{1'b1}}, 64'd31, 0, 47);
        queue_random_refs(PHASE_REFS);

        // window length zero, distance taken from the low bits only
        set_phase(64'hFFFF_0000_0000_0100, 64'd0, 9, 9);
        queue_random_refs(PHASE_REFS);

        // receiver holds off while the sender keeps offering
        set_phase(64'(($urandom & 32'h000F_FFFF) | 32'h1), 64'd16, 0, 0);
        long_stall_arm = 1'b1;
        queue_random_refs(PHASE_REFS);

        // sender pauses halfway until all results are back
        set_phase(64'd1000, 64'hFFFF_FFFF_FFFF_FFE3, 47, 0);
        queue_random_refs(PHASE_REFS / 2);
        wait_idle();
        queue_random_refs(PHASE_REFS / 2);

        set_phase(64'd4096, 64'd8, 0, 0);
        queue_random_refs(PHASE_REFS);

        wait_idle();
        if (reports_due.size() != 0) begin
            $error("%0d results never arrived", reports_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS locality_cluster_segmenter");
        end else begin
            $display("FAIL locality_cluster_segmenter");
        end
        $finish;
    end

endmodule
